FILE: hdl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

FILE: hdl/rau_pkg.sv
// Package: opcodes, controller states and command/status types.
package rau_pkg;
  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3, OP_CMP = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL0, ST_MUL1, ST_MUL2, ST_FORM, ST_GCD, ST_DIVN, ST_DIVD, ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    CMD_NONE, CMD_LOAD, CMD_MUL0, CMD_MUL1, CMD_MUL2, CMD_FORM, CMD_GCD, CMD_DIV
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
    logic div_start;
    logic div_sel_d;  // 0 numerator, 1 denominator
    logic store_n;
    logic store_d;
    logic out_load;
  } ctl_t;

  typedef struct packed {
    logic gcd_done;
    logic div_done;
    logic is_arith;
  } sts_t;
endpackage

FILE: hdl/rau_ctrl.sv
// Controller state machine for the rational arithmetic unit.
module rau_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           out_valid_q_i,
  input  logic           out_stall_i,
  input  rau_pkg::sts_t  sts_i,
  output rau_pkg::ctl_t  ctl_o
);
  import rau_pkg::*;

  state_e state_q, state_d;
  logic   out_free;

  assign out_free = !out_valid_q_i || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_MUL0;
      ST_MUL0: state_d = ST_MUL1;
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_FORM;
      ST_FORM: state_d = sts_i.is_arith ? ST_GCD : ST_DONE;
      ST_GCD:  if (sts_i.gcd_done) state_d = ST_DIVN;
      ST_DIVN: if (sts_i.div_done) state_d = ST_DIVD;
      ST_DIVD: if (sts_i.div_done) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o = '0;
    ctl_o.cmd = CMD_NONE;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        ctl_o.cmd  = in_valid_i ? CMD_LOAD : CMD_NONE;
      end
      ST_MUL0: ctl_o.cmd = CMD_MUL0;
      ST_MUL1: ctl_o.cmd = CMD_MUL1;
      ST_MUL2: ctl_o.cmd = CMD_MUL2;
      ST_FORM: begin
        ctl_o.cmd = CMD_FORM;
      end
      ST_GCD: begin
        ctl_o.cmd = CMD_GCD;
        ctl_o.div_start = sts_i.gcd_done;
      end
      ST_DIVN: begin
        ctl_o.cmd = CMD_DIV;
        ctl_o.store_n = sts_i.div_done;
        ctl_o.div_start = sts_i.div_done;
        ctl_o.div_sel_d = sts_i.div_done;
      end
      ST_DIVD: begin
        ctl_o.cmd = CMD_DIV;
        ctl_o.div_sel_d = 1'b1;
        ctl_o.store_d = sts_i.div_done;
      end
      ST_DONE: ctl_o.out_load = out_free;
      default: ;
    endcase
  end
endmodule

FILE: hdl/rau_dp.sv
// Datapath: products, sign fix, binary gcd, restoring divider, result hold.
module rau_dp #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rau_pkg::ctl_t        ctl_i,
  output rau_pkg::sts_t        sts_o,
  input  logic [2:0]           opcode_i,
  input  logic [63:0]          a_numer_i,
  input  logic [63:0]          a_denom_i,
  input  logic [63:0]          b_numer_i,
  input  logic [63:0]          b_denom_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic signed [63:0]   res_numer_o,
  output logic signed [63:0]   res_denom_o,
  output logic signed [1:0]    cmp_sign_o,
  output logic                 undefined_o
);
  import rau_pkg::*;

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned H  = (W + 1) / 2;
  localparam int unsigned CW = $clog2(W + 1);

  logic [2:0]   op_q;
  logic [W-1:0] an_q, ad_q, bn_q, bd_q;
  logic [W-1:0] p0_q, p1_q, p2_q;
  logic [W-1:0] n_q, d_q;
  logic [W-1:0] gx_q, gy_q;
  logic [CW-1:0] gk_q;
  logic         gdone_q;
  logic [W-1:0] quo_q, rem_q, dvd_q;
  logic [CW-1:0] dcnt_q;
  logic         dbusy_q;
  logic [W-1:0] rn_q, rd_q;
  logic [W-1:0] g_val;

  // partial-product multiply: x*y mod 2^W from three half-width products
  logic [W-1:0] mx, my, mprod;
  always_comb begin
    mx = an_q; my = bd_q;
    unique case (ctl_i.cmd)
      CMD_MUL0: begin mx = an_q; my = (op_q == OP_MUL) ? bn_q : bd_q; end
      CMD_MUL1: begin
        mx = (op_q == OP_DIV) ? ad_q : bn_q;
        my = (op_q == OP_DIV) ? bn_q : ad_q;
      end
      default: begin mx = ad_q; my = bd_q; end
    endcase
  end
  // low halves full product plus cross terms shifted; cross terms wrap
  logic [W-1:0] xl, xh, yl, yh;
  assign xl = mx & ((W'(1) << H) - W'(1));
  assign yl = my & ((W'(1) << H) - W'(1));
  assign xh = mx >> H;
  assign yh = my >> H;
  assign mprod = W'(xl * yl) + W'((xl * yh + xh * yl) << H);

  logic [W-1:0] n_raw, d_raw, n_fix, d_fix, diff;
  assign diff  = p0_q - p1_q;
  always_comb begin
    unique case (op_q)
      OP_ADD:  n_raw = p0_q + p1_q;
      OP_SUB:  n_raw = diff;
      default: n_raw = p0_q;
    endcase
    d_raw = (op_q == OP_DIV) ? p1_q : p2_q;
    n_fix = d_raw[W-1] ? W'(0) - n_raw : n_raw;
    d_fix = d_raw[W-1] ? W'(0) - d_raw : d_raw;
  end

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    mag = v[W-1] ? W'(0) - v : v;
  endfunction

  assign sts_o.is_arith = (op_q <= 3'(OP_DIV));
  assign sts_o.gcd_done = gdone_q;
  assign sts_o.div_done = dbusy_q && (dcnt_q == '0);
  assign g_val = gx_q << gk_q;

  // divider step
  logic [W:0] rtrial;
  assign rtrial = {rem_q, dvd_q[W-1]} - {1'b0, g_val};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gdone_q     <= 1'b0;
      dbusy_q     <= 1'b0;
      dcnt_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      if (ctl_i.out_load) out_valid_o <= 1'b1;
      gdone_q <= 1'b0;
      unique case (ctl_i.cmd)
        CMD_LOAD: begin
          op_q <= opcode_i;
          an_q <= a_numer_i[W-1:0]; ad_q <= a_denom_i[W-1:0];
          bn_q <= b_numer_i[W-1:0]; bd_q <= b_denom_i[W-1:0];
        end
        CMD_MUL0: p0_q <= mprod;
        CMD_MUL1: p1_q <= mprod;
        CMD_MUL2: p2_q <= mprod;
        CMD_FORM: begin
          n_q <= n_fix; d_q <= d_fix;
          gx_q <= mag(n_fix); gy_q <= mag(d_fix); gk_q <= '0;
          rn_q <= '0; rd_q <= W'(1);
        end
        CMD_GCD: if (!gdone_q) begin
          // binary gcd, one step a cycle
          if (gx_q == '0 || gy_q == '0) begin
            gx_q    <= gx_q | gy_q;
            gy_q    <= '0;
            gdone_q <= 1'b1;
          end else if (!gx_q[0] && !gy_q[0]) begin
            gx_q <= gx_q >> 1; gy_q <= gy_q >> 1; gk_q <= gk_q + CW'(1);
          end else if (!gx_q[0]) begin
            gx_q <= gx_q >> 1;
          end else if (!gy_q[0]) begin
            gy_q <= gy_q >> 1;
          end else if (gx_q >= gy_q) begin
            gx_q <= (gx_q - gy_q) >> 1;
          end else begin
            gy_q <= (gy_q - gx_q) >> 1;
          end
        end
        CMD_DIV: if (dbusy_q && dcnt_q != '0) begin
          if (!rtrial[W]) begin
            rem_q <= rtrial[W-1:0]; quo_q <= {quo_q[W-2:0], 1'b1};
          end else begin
            rem_q <= {rem_q[W-2:0], dvd_q[W-1]}; quo_q <= {quo_q[W-2:0], 1'b0};
          end
          dvd_q  <= dvd_q << 1;
          dcnt_q <= dcnt_q - CW'(1);
        end
        default: ;
      endcase
      if (sts_o.div_done) dbusy_q <= 1'b0;
      if (ctl_i.store_n) rn_q <= n_q[W-1] ? W'(0) - quo_q : quo_q;
      if (ctl_i.store_d) rd_q <= d_q[W-1] ? W'(0) - quo_q : quo_q;
      if (ctl_i.div_start) begin
        dvd_q   <= ctl_i.div_sel_d ? mag(d_q) : mag(n_q);
        rem_q   <= '0;
        quo_q   <= '0;
        dcnt_q  <= CW'(W);
        dbusy_q <= 1'b1;
      end
    end
  end

  // result register, loaded when the controller hands the word over
  logic gzero;
  assign gzero = (g_val == '0);
  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      if (op_q == OP_CMP) begin
        res_numer_o <= '0;
        res_denom_o <= 64'sd1;
        undefined_o <= 1'b0;
        cmp_sign_o  <= (diff == '0) ? 2'sd0 : (diff[W-1] ? -2'sd1 : 2'sd1);
      end else if (sts_o.is_arith) begin
        res_numer_o <= gzero ? '0 : 64'(signed'(rn_q));
        res_denom_o <= gzero ? '0 : 64'(signed'(rd_q));
        undefined_o <= gzero;
        cmp_sign_o  <= '0;
      end else begin
        res_numer_o <= '0;
        res_denom_o <= 64'sd1;
        undefined_o <= 1'b0;
        cmp_sign_o  <= '0;
      end
    end
  end
endmodule

FILE: hdl/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit.
//   channel | valid      | stall       | payload
//   in      | in_valid_i | in_stall_o  | opcode_i, a/b numer/denom
//   out     | out_valid_o| out_stall_i | res_numer_o, res_denom_o, cmp_sign_o, undefined_o
// One word at a time. An accepted word passes through the multiply steps, the form
// step, the binary gcd loop and the numerator and denominator divides before out_valid_o;
// the gcd loop runs one step at a time and the divider is bit-serial. Compare and
// opcodes five to seven skip the gcd and divide steps.
// The next word can be accepted in the cycle after the result loads.
// Reset clears the controller and output valid; no clearing pass.
// A stalled result holds in the output register; the next word still runs, then
// waits in its last step with the input stalled until the register frees.
module rational_arithmetic_unit #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         opcode_i,
  input  logic signed [63:0] a_numer_i,
  input  logic signed [63:0] a_denom_i,
  input  logic signed [63:0] b_numer_i,
  input  logic signed [63:0] b_denom_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [63:0] res_numer_o,
  output logic signed [63:0] res_denom_o,
  output logic signed [1:0]  cmp_sign_o,
  output logic               undefined_o
);
  import rau_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // controller sequences load, multiply, form, gcd and divide commands
  rau_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .out_valid_q_i(out_valid_o), .out_stall_i,
    .sts_i(sts), .ctl_o(ctl)
  );

  rau_dp #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl), .sts_o(sts),
    .opcode_i,
    .a_numer_i(a_numer_i), .a_denom_i(a_denom_i),
    .b_numer_i(b_numer_i), .b_denom_i(b_denom_i),
    .out_stall_i, .out_valid_o,
    .res_numer_o, .res_denom_o, .cmp_sign_o, .undefined_o
  );
endmodule

FILE: hdl/rau_checker.sv
// Port-level checker for the rational arithmetic unit, bound to the top level.
`include "assert_macros.svh"
module rau_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic signed [1:0] cmp_sign_o,
  input logic              undefined_o,
  input logic signed [63:0] res_numer_o
);
  `ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `ASSERT_IMPL(a_cmp_code, clk_i, rst_ni, out_valid_o, cmp_sign_o != 2'b10)
  `ASSERT_IMPL(a_undef_zero, clk_i, rst_ni, out_valid_o && undefined_o, res_numer_o == '0)
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .cmp_sign_o, .undefined_o, .res_numer_o
);
